/* hw/rtl/obbp_pkg.sv */
// ----------------------------------------------------------------------------
// obbp_pkg
// shared constants and types for the best-price order book
// ----------------------------------------------------------------------------
package obbp_pkg;

    localparam int MAX_ORDERS_DEF = 1024;
    localparam int MAX_LEVELS_DEF = 256;
    localparam int PRICE_BITS_DEF = 32;
    localparam int ID_BITS        = 10;
    localparam int TIME_BITS      = 32;
    localparam int SUM_BITS       = 63;
    localparam int COUNT_BITS     = 11;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_UNKNOWN = 2'd1,
        ST_DUP     = 2'd2,
        ST_FULL    = 2'd3
    } status_t;

    // operation broadcast to every level cell
    typedef enum logic [2:0] {
        OP_NONE   = 3'd0,   // hold
        OP_INSERT = 3'd1,   // open a new level for the key
        OP_BUMP   = 3'd2,   // one more order on the matching level
        OP_ERASE  = 3'd3,   // one order fewer on the matching level
        OP_REMOVE = 3'd4    // drop the matching level, shift the rest down
    } op_t;

endpackage

/* hw/rtl/obbp_cell.sv */
// ----------------------------------------------------------------------------
// obbp_cell
// one price level of the sorted chain, ascending from index 0
// ----------------------------------------------------------------------------
module obbp_cell #(
    parameter int PRICE_BITS = obbp_pkg::PRICE_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  obbp_pkg::op_t                   op,
    input  logic [PRICE_BITS-1:0]           key,
    // lower neighbor
    input  logic                            lo_used,
    input  logic                            lo_less,
    input  logic [PRICE_BITS-1:0]           lo_price,
    input  logic [obbp_pkg::COUNT_BITS-1:0] lo_count,
    // upper neighbor
    input  logic [PRICE_BITS-1:0]           hi_price,
    input  logic [obbp_pkg::COUNT_BITS-1:0] hi_count,
    output logic                            used,
    output logic                            less,
    output logic                            match,
    output logic                            gone,
    output logic [PRICE_BITS-1:0]           price,
    output logic [obbp_pkg::COUNT_BITS-1:0] count
);
    localparam int CB = obbp_pkg::COUNT_BITS;

    logic [PRICE_BITS-1:0] price_reg, price_next;
    logic [CB-1:0]         count_reg, count_next;

    // compare against the key
    assign used  = (count_reg != '0);
    assign less  = used && (price_reg < key);
    assign match = used && (price_reg == key);
    assign price = price_reg;
    assign count = count_reg;
    // a matching single-order level disappears on erase
    assign gone  = match && (count_reg == CB'(1));

    // next contents
    always_comb
    begin
        price_next = price_reg;
        count_next = count_reg;
        case (op)
            obbp_pkg::OP_INSERT:
            begin
                // the first cell not below the key takes it, the ones above shift up
                if (!less)
                begin
                    if (lo_less)
                    begin
                        price_next = key;
                        count_next = CB'(1);
                    end
                    else if (lo_used)
                    begin
                        price_next = lo_price;
                        count_next = lo_count;
                    end
                end
            end
            obbp_pkg::OP_BUMP:
            begin
                if (match)
                begin
                    count_next = count_reg + CB'(1);
                end
            end
            obbp_pkg::OP_ERASE:
            begin
                if (match)
                begin
                    count_next = count_reg - CB'(1);
                end
            end
            obbp_pkg::OP_REMOVE:
            begin
                // the removed level and every level above it take the upper neighbor
                if (used && !less)
                begin
                    price_next = hi_price;
                    count_next = hi_count;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        price_reg <= price_next;
    end

endmodule

/* hw/rtl/order_book_best_price_twap.sv */
// ----------------------------------------------------------------------------
// order_book_best_price_twap
// limit order book keeping a time-weighted sum of the best price
// ----------------------------------------------------------------------------
// steps from taking a request to handing over its result: id table read, level
//   update with the interval multiply, sum, result
// one request in flight: a new request is taken only once the result is handed over
// the level chain shifts in the apply step, which follows the id table read
// reset: asynchronous, clears level counts and timing state, then clears the live
//   table one entry a cycle, all MAX_ORDERS entries (1024 by default), input stalled
// ----------------------------------------------------------------------------
module order_book_best_price_twap #(
    parameter int MAX_ORDERS = obbp_pkg::MAX_ORDERS_DEF,
    parameter int MAX_LEVELS = obbp_pkg::MAX_LEVELS_DEF,
    parameter int PRICE_BITS = obbp_pkg::PRICE_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [obbp_pkg::TIME_BITS-1:0] event_time,
    input  logic                           command,
    input  logic [obbp_pkg::ID_BITS-1:0]   order_id,
    input  logic [31:0]                    price_ticks,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [31:0]                    best_price,
    output logic                           book_empty,
    output logic [obbp_pkg::SUM_BITS-1:0]  weighted_sum,
    output logic [obbp_pkg::TIME_BITS-1:0] elapsed_time,
    output logic [1:0]                     status
);
    localparam int OA = (MAX_ORDERS > 1) ? $clog2(MAX_ORDERS) : 1;
    localparam int CB = obbp_pkg::COUNT_BITS;
    localparam logic [63:0] SUM_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_READ  = 6'b000100,
        S_APPLY = 6'b001000,
        S_SUM   = 6'b010000,
        S_OUT   = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    // captured request
    logic [obbp_pkg::TIME_BITS-1:0] t_reg;
    logic                           cmd_reg;
    logic [obbp_pkg::ID_BITS-1:0]   id_reg;
    logic [PRICE_BITS-1:0]          p_reg;
    logic                           id_ok_reg;

    // id tables
    logic [PRICE_BITS-1:0] id_mem [MAX_ORDERS];
    logic                  live_mem [MAX_ORDERS];
    logic [PRICE_BITS-1:0] rd_price_reg;
    logic                  rd_live_reg;
    logic [OA-1:0]         clr_reg;
    logic                  clr_last;
    logic                  id_set, id_clr;

    // timing state
    logic [obbp_pkg::TIME_BITS-1:0] prev_reg, start_reg;
    logic                           seen_reg;
    logic [63:0]                    sum_reg;
    logic [63:0]                    prod_reg;
    logic                           add_reg;
    logic [1:0]                     st_reg;

    // chain wiring
    logic [MAX_LEVELS-1:0] c_used, c_less, c_match, c_gone, c_top;
    logic [PRICE_BITS-1:0] c_price [MAX_LEVELS];
    logic [CB-1:0]         c_count [MAX_LEVELS];
    obbp_pkg::op_t         op;
    logic [PRICE_BITS-1:0] key;

    logic accept;
    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != S_IDLE);
    assign clr_last = (clr_reg == OA'(MAX_ORDERS - 1));

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR: if (clr_last) state_next = S_IDLE;
            S_IDLE:  if (in_valid) state_next = S_READ;
            S_READ:  state_next = S_APPLY;
            S_APPLY: state_next = S_SUM;
            S_SUM:   state_next = S_OUT;
            S_OUT:   if (!out_stall) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // best price from the highest used level, with interval length
    logic [PRICE_BITS-1:0]          best_pre;
    logic                           empty_pre;
    logic [obbp_pkg::TIME_BITS-1:0] dt;
    assign c_top     = c_used & ~(c_used >> 1);
    assign empty_pre = !c_used[0];
    assign dt = (t_reg >= prev_reg) ? (t_reg - prev_reg) : '0;
    always_comb
    begin
        best_pre = '0;
        for (int i = 0; i < MAX_LEVELS; i++)
        begin
            best_pre = best_pre | (c_top[i] ? c_price[i] : '0);
        end
    end

    // level lookup and status in the apply cycle
    logic any_match, any_gone, full;
    logic [1:0] st_calc;
    assign any_match = |c_match;
    assign any_gone  = |c_gone;
    assign full      = c_used[MAX_LEVELS-1];
    always_comb
    begin
        st_calc = obbp_pkg::ST_OK;
        op      = obbp_pkg::OP_NONE;
        key     = cmd_reg ? rd_price_reg : p_reg;
        if (state_reg == S_APPLY)
        begin
            if (!cmd_reg)
            begin
                if (!id_ok_reg)        st_calc = obbp_pkg::ST_FULL;
                else if (rd_live_reg)  st_calc = obbp_pkg::ST_DUP;
                else if (any_match)    op = obbp_pkg::OP_BUMP;
                else if (full)         st_calc = obbp_pkg::ST_FULL;
                else                   op = obbp_pkg::OP_INSERT;
            end
            else
            begin
                if (!id_ok_reg || !rd_live_reg) st_calc = obbp_pkg::ST_UNKNOWN;
                else if (any_gone)              op = obbp_pkg::OP_REMOVE;
                else                            op = obbp_pkg::OP_ERASE;
            end
        end
    end
    assign id_set = (op == obbp_pkg::OP_INSERT) || (op == obbp_pkg::OP_BUMP);
    assign id_clr = (op == obbp_pkg::OP_ERASE) || (op == obbp_pkg::OP_REMOVE);

    // the level chain
    for (genvar g = 0; g < MAX_LEVELS; g++)
    begin : g_cell
        logic                  lo_u, lo_l;
        logic [PRICE_BITS-1:0] lo_p, hi_p;
        logic [CB-1:0]         lo_c, hi_c;
        if (g == 0)
        begin : g_lo0
            // below the bottom level everything counts as less than the key
            assign lo_u = 1'b1;
            assign lo_l = 1'b1;
            assign lo_p = '0;
            assign lo_c = '0;
        end
        else
        begin : g_lo
            assign lo_u = c_used[g-1];
            assign lo_l = c_less[g-1];
            assign lo_p = c_price[g-1];
            assign lo_c = c_count[g-1];
        end
        if (g == MAX_LEVELS - 1)
        begin : g_hiN
            assign hi_p = '0;
            assign hi_c = '0;
        end
        else
        begin : g_hi
            assign hi_p = c_price[g+1];
            assign hi_c = c_count[g+1];
        end
        obbp_cell #(.PRICE_BITS(PRICE_BITS)) u_cell (
            .clk(clk), .rst_n(rst_n), .op(op), .key(key),
            .lo_used(lo_u), .lo_less(lo_l), .lo_price(lo_p), .lo_count(lo_c),
            .hi_price(hi_p), .hi_count(hi_c),
            .used(c_used[g]), .less(c_less[g]), .match(c_match[g]),
            .gone(c_gone[g]), .price(c_price[g]), .count(c_count[g])
        );
    end

    // request capture, id table read and write
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            t_reg     <= event_time;
            cmd_reg   <= command;
            id_reg    <= order_id;
            p_reg     <= PRICE_BITS'(price_ticks);
            id_ok_reg <= ({{(32-obbp_pkg::ID_BITS){1'b0}}, order_id} < 32'(MAX_ORDERS));
        end
        if (state_reg == S_READ)
        begin
            rd_price_reg <= id_mem[OA'(id_reg)];
            rd_live_reg  <= live_mem[OA'(id_reg)];
        end
        if (id_set)
        begin
            id_mem[OA'(id_reg)] <= p_reg;
        end
        if (state_reg == S_CLEAR)
        begin
            live_mem[clr_reg] <= 1'b0;
        end
        else if (id_set)
        begin
            live_mem[OA'(id_reg)] <= 1'b1;
        end
        else if (id_clr)
        begin
            live_mem[OA'(id_reg)] <= 1'b0;
        end
        if (state_reg == S_APPLY)
        begin
            prod_reg <= 64'(dt) * 64'(best_pre);
            add_reg  <= seen_reg && !empty_pre && (dt != '0);
        end
    end

    logic [64:0] sum_wide;
    assign sum_wide = {1'b0, sum_reg} + {1'b0, prod_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            clr_reg     <= '0;
            prev_reg    <= '0;
            start_reg   <= '0;
            seen_reg    <= 1'b0;
            sum_reg     <= '0;
            st_reg      <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_CLEAR)
                clr_reg <= clr_reg + OA'(1);
            if (state_reg == S_APPLY)
                st_reg <= st_calc;
            if (state_reg == S_SUM)
            begin
                if (!seen_reg) start_reg <= t_reg;
                seen_reg <= 1'b1;
                prev_reg <= t_reg;
                if (add_reg)
                begin
                    if (sum_wide > {1'b0, SUM_MAX}) sum_reg <= SUM_MAX;
                    else                            sum_reg <= sum_wide[63:0];
                end
            end
        end
    end

    // result
    assign out_valid    = (state_reg == S_OUT);
    assign best_price   = 32'(best_pre);
    assign book_empty   = empty_pre;
    assign weighted_sum = sum_reg[obbp_pkg::SUM_BITS-1:0];
    assign elapsed_time = t_reg - start_reg;
    assign status       = st_reg;

    // checks
    a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall) else $error("accept while result pending");
    a_sum_cap: assert property (@(posedge clk) disable iff (!rst_n)
        sum_reg <= SUM_MAX) else $error("sum above cap");
    a_chain_packed: assert property (@(posedge clk) disable iff (!rst_n)
        ((c_used >> 1) & ~c_used) == '0) else $error("level chain not packed");
    a_empty_best: assert property (@(posedge clk) disable iff (!rst_n)
        book_empty |-> (best_pre == '0)) else $error("best price in empty book");
endmodule
